/* src/thermostat_relay_controller_unit_defines.svh */
// Assertion macros shared by the thermostat relay controller RTL.
// Included by the top level; depends on nothing else.
`ifndef THERMOSTAT_RELAY_CONTROLLER_UNIT_DEFINES_SVH
`define THERMOSTAT_RELAY_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/trc_pkg.sv */
// Package for the thermostat relay controller: command, override and
// register index codes, and the configuration reset values. No dependencies.
package trc_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] ovr_t;
	typedef logic       reg_idx_t;

	localparam cmd_t CMD_EVAL  = 2'd0;
	localparam cmd_t CMD_SET   = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;

	localparam ovr_t OVR_NONE = 2'd0;
	localparam ovr_t OVR_ON   = 2'd1;
	localparam ovr_t OVR_OFF  = 2'd2;
	localparam ovr_t OVR_BAD  = 2'd3;

	localparam reg_idx_t REG_UPPER_LIMIT = 1'b0;
	localparam reg_idx_t REG_MIN_CYCLE   = 1'b1;

	localparam longint UPPER_LIMIT_RESET = 560;
	localparam longint MIN_CYCLE_RESET   = 300000;

endpackage

/* src/trc_in_if.sv */
// Request channel of the thermostat relay controller: valid/ready handshake
// and the fields of one input item. Uses the codes of trc_pkg.
interface trc_in_if #(
	parameter int TIME_BITS = 32,
	parameter int TEMP_BITS = 16
);
	logic                        valid;
	logic                        ready;
	trc_pkg::cmd_t               command;
	logic [TIME_BITS-1:0]        now_ms;
	logic signed [TEMP_BITS-1:0] temperature;
	logic signed [TEMP_BITS-1:0] on_below_temp;
	logic signed [TEMP_BITS-1:0] off_above_temp;
	logic                        schedule_on;
	logic                        reading_ok;
	trc_pkg::ovr_t               override_request;
	logic [TIME_BITS-1:0]        override_length_ms;

	modport source (
		output valid, command, now_ms, temperature, on_below_temp, off_above_temp,
		output schedule_on, reading_ok, override_request, override_length_ms,
		input  ready
	);

	modport sink (
		input  valid, command, now_ms, temperature, on_below_temp, off_above_temp,
		input  schedule_on, reading_ok, override_request, override_length_ms,
		output ready
	);
endinterface

/* src/trc_out_if.sv */
// Result channel of the thermostat relay controller: valid/ready handshake
// and the fields of one result item. Uses the codes of trc_pkg.
interface trc_out_if #(
	parameter int TIME_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic                 relay_state;
	logic                 relay_changed;
	logic                 cutoff_active;
	trc_pkg::ovr_t        override_now;
	logic [TIME_BITS-1:0] override_remaining_ms;
	logic [TIME_BITS-1:0] last_switch_ms;

	modport source (
		output valid, relay_state, relay_changed, cutoff_active, override_now,
		output override_remaining_ms, last_switch_ms,
		input  ready
	);

	modport sink (
		input  valid, relay_state, relay_changed, cutoff_active, override_now,
		input  override_remaining_ms, last_switch_ms,
		output ready
	);
endinterface

/* src/thermostat_relay_controller_unit.sv */
// Thermostat relay controller: an accepted item waits in the item register until the result
// register is free or being taken, then loads it; one item is accepted every cycle unless results stall.
// The item register feeds a single pass of comparators and subtractors that
// updates the relay, cutoff, override and switch stamp state and loads the result register.
// The asynchronous active-low reset turns the relay off, clears the override and stamp,
// empties both stages and loads the configuration registers with their defaults.
`include "thermostat_relay_controller_unit_defines.svh"

module thermostat_relay_controller_unit #(
	parameter int TIME_BITS = 32,
	parameter int TEMP_BITS = 16,
	localparam int DataW = (TIME_BITS > TEMP_BITS) ? TIME_BITS : TEMP_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	trc_in_if.sink              request,
	trc_out_if.source           result,
	input  logic                wr_en,
	input  trc_pkg::reg_idx_t   wr_index,
	input  logic [DataW-1:0]    wr_data
);

	// Item register.
	logic                        valid_s1;
	trc_pkg::cmd_t               command_s1;
	logic [TIME_BITS-1:0]        now_s1;
	logic signed [TEMP_BITS-1:0] temp_s1;
	logic signed [TEMP_BITS-1:0] open_s1;
	logic signed [TEMP_BITS-1:0] close_s1;
	logic                        sched_s1;
	logic                        sensor_s1;
	trc_pkg::ovr_t               req_s1;
	logic [TIME_BITS-1:0]        len_s1;

	// Configuration and controller state.
	logic signed [TEMP_BITS-1:0] upper_limit_q;
	logic [TIME_BITS-1:0]        min_cycle_q;
	logic                        relay_q;
	logic                        cutoff_q;
	trc_pkg::ovr_t               ovr_mode_q;
	logic [TIME_BITS-1:0]        ovr_start_q;
	logic [TIME_BITS-1:0]        ovr_len_q;
	logic [TIME_BITS-1:0]        last_switch_q;

	// Result register.
	logic                        out_valid_q;
	logic                        out_relay_q;
	logic                        out_changed_q;
	logic                        out_cutoff_q;
	trc_pkg::ovr_t               out_ovr_q;
	logic [TIME_BITS-1:0]        out_remaining_q;
	logic [TIME_BITS-1:0]        out_last_q;

	logic                        advance;
	logic [TIME_BITS-1:0]        ovr_elapsed;
	logic [TIME_BITS:0]          ovr_diff;
	logic                        ovr_running;
	logic                        ovr_expired;
	logic [TIME_BITS-1:0]        remaining_pre;
	trc_pkg::ovr_t               mode_eval;
	logic                        cutoff_c;
	logic                        may_switch;
	logic                        want;
	logic                        changed_c;
	logic                        relay_n;
	logic                        cutoff_n;
	trc_pkg::ovr_t               mode_n;
	logic [TIME_BITS-1:0]        start_n;
	logic [TIME_BITS-1:0]        len_n;
	logic [TIME_BITS-1:0]        last_n;
	logic [TIME_BITS-1:0]        remaining_n;

	assign advance       = valid_s1 && (!out_valid_q || result.ready);
	assign request.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			command_s1 <= request.command;
			now_s1     <= request.now_ms;
			temp_s1    <= request.temperature;
			open_s1    <= request.on_below_temp;
			close_s1   <= request.off_above_temp;
			sched_s1   <= request.schedule_on;
			sensor_s1  <= request.reading_ok;
			req_s1     <= request.override_request;
			len_s1     <= request.override_length_ms;
		end
	end

	// The override is still running while its elapsed time is below its length.
	assign ovr_elapsed   = now_s1 - ovr_start_q;
	assign ovr_diff      = {1'b0, ovr_len_q} - {1'b0, ovr_elapsed};
	assign ovr_running   = !ovr_diff[TIME_BITS] && (ovr_diff[TIME_BITS-1:0] != '0);
	assign ovr_expired   = (ovr_len_q != '0) && !ovr_running;
	assign remaining_pre = (ovr_mode_q != trc_pkg::OVR_NONE && ovr_len_q != '0 && ovr_running)
		? ovr_diff[TIME_BITS-1:0] : '0;
	assign mode_eval     = ovr_expired ? trc_pkg::OVR_NONE : ovr_mode_q;

	assign cutoff_c   = sensor_s1 && (temp_s1 >= upper_limit_q);
	assign may_switch = (last_switch_q == '0) || ((now_s1 - last_switch_q) >= min_cycle_q);

	always_comb begin
		if (cutoff_c) begin
			want = 1'b0;
		end else if (mode_eval == trc_pkg::OVR_ON) begin
			want = 1'b1;
		end else if (mode_eval == trc_pkg::OVR_OFF) begin
			want = 1'b0;
		end else if (!sensor_s1 || !sched_s1) begin
			want = 1'b0;
		end else if (temp_s1 < open_s1) begin
			want = 1'b1;
		end else if (temp_s1 > close_s1) begin
			want = 1'b0;
		end else begin
			want = relay_q;
		end
	end

	always_comb begin
		relay_n     = relay_q;
		cutoff_n    = cutoff_q;
		mode_n      = ovr_mode_q;
		start_n     = ovr_start_q;
		len_n       = ovr_len_q;
		last_n      = last_switch_q;
		changed_c   = 1'b0;
		remaining_n = remaining_pre;
		case (command_s1)
			trc_pkg::CMD_EVAL: begin
				if (ovr_expired) begin
					mode_n  = trc_pkg::OVR_NONE;
					start_n = '0;
					len_n   = '0;
				end
				cutoff_n = cutoff_c;
				if (want != relay_q && may_switch) begin
					relay_n   = want;
					last_n    = now_s1;
					changed_c = 1'b1;
				end
			end
			trc_pkg::CMD_SET: begin
				if (req_s1 != trc_pkg::OVR_BAD) begin
					mode_n      = req_s1;
					len_n       = len_s1;
					start_n     = (len_s1 != '0) ? now_s1 : '0;
					remaining_n = (req_s1 != trc_pkg::OVR_NONE) ? len_s1 : '0;
				end
			end
			trc_pkg::CMD_CLEAR: begin
				mode_n      = trc_pkg::OVR_NONE;
				start_n     = '0;
				len_n       = '0;
				remaining_n = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_limit_q <= TEMP_BITS'(trc_pkg::UPPER_LIMIT_RESET);
			min_cycle_q   <= TIME_BITS'(trc_pkg::MIN_CYCLE_RESET);
		end else if (wr_en) begin
			if (wr_index == trc_pkg::REG_UPPER_LIMIT) begin
				upper_limit_q <= wr_data[TEMP_BITS-1:0];
			end
			if (wr_index == trc_pkg::REG_MIN_CYCLE) begin
				min_cycle_q <= wr_data[TIME_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q       <= 1'b0;
			cutoff_q      <= 1'b0;
			ovr_mode_q    <= trc_pkg::OVR_NONE;
			ovr_start_q   <= '0;
			ovr_len_q     <= '0;
			last_switch_q <= '0;
		end else if (advance) begin
			relay_q       <= relay_n;
			cutoff_q      <= cutoff_n;
			ovr_mode_q    <= mode_n;
			ovr_start_q   <= start_n;
			ovr_len_q     <= len_n;
			last_switch_q <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_relay_q     <= relay_n;
			out_changed_q   <= changed_c;
			out_cutoff_q    <= cutoff_n;
			out_ovr_q       <= mode_n;
			out_remaining_q <= remaining_n;
			out_last_q      <= last_n;
		end
	end

	assign result.valid                 = out_valid_q;
	assign result.relay_state           = out_relay_q;
	assign result.relay_changed         = out_changed_q;
	assign result.cutoff_active         = out_cutoff_q;
	assign result.override_now          = out_ovr_q;
	assign result.override_remaining_ms = out_remaining_q;
	assign result.last_switch_ms        = out_last_q;

	`TRC_ASSERT_NEXT(a_stamp_on_change, clk, arst_n, advance && changed_c, last_switch_q == $past(now_s1))
	`TRC_ASSERT_NEXT(a_relay_holds_idle, clk, arst_n, !advance, $stable(relay_q) && $stable(last_switch_q))
	`TRC_ASSERT_NEXT(a_cutoff_forces_off, clk, arst_n, advance && command_s1 == trc_pkg::CMD_EVAL && cutoff_c && may_switch, !relay_q)
	`TRC_ASSERT_NOW(a_mode_legal, clk, arst_n, 1'b1, ovr_mode_q != trc_pkg::OVR_BAD)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for thermostat_relay_controller_unit: runs directed and random items
// through both channels and checks every result against a shadow model of the relay logic.
// Depends on trc_pkg, trc_in_if, trc_out_if and the unit itself.
module tb_top;

	localparam trc_pkg::cmd_t CMD_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		trc_pkg::cmd_t      command;
		logic [31:0]        now_ms;
		logic signed [15:0] temperature;
		logic signed [15:0] on_below_temp;
		logic signed [15:0] off_above_temp;
		logic               schedule_on;
		logic               reading_ok;
		trc_pkg::ovr_t      override_request;
		logic [31:0]        override_length_ms;
	} request_t;

	typedef struct {
		logic          relay_state;
		logic          relay_changed;
		logic          cutoff_active;
		trc_pkg::ovr_t override_now;
		logic [31:0]   override_remaining_ms;
		logic [31:0]   last_switch_ms;
	} status_t;

	class thermostat_shadow;
		logic signed [15:0] upper_limit;
		logic [31:0]        min_cycle;
		logic               relay_lvl;
		logic               cutoff;
		trc_pkg::ovr_t      ovr_mode;
		logic [31:0]        ovr_start;
		logic [31:0]        ovr_length;
		logic [31:0]        last_switch;
		status_t            due_results[$];
		int                 errors;

		function new();
			upper_limit = 16'(trc_pkg::UPPER_LIMIT_RESET);
			min_cycle = 32'(trc_pkg::MIN_CYCLE_RESET);
			relay_lvl = 1'b0;
			cutoff = 1'b0;
			ovr_mode = trc_pkg::OVR_NONE;
			ovr_start = '0;
			ovr_length = '0;
			last_switch = '0;
			errors = 0;
		endfunction

		function void set_register(trc_pkg::reg_idx_t idx, logic [31:0] value);
			case (idx)
				trc_pkg::REG_UPPER_LIMIT: upper_limit = value[15:0];
				trc_pkg::REG_MIN_CYCLE: min_cycle = value;
				default: ;
			endcase
		endfunction

		function void clear_override();
			ovr_mode = trc_pkg::OVR_NONE;
			ovr_start = '0;
			ovr_length = '0;
		endfunction

		function bit drive_relay(logic want, logic [31:0] now);
			logic [31:0] since;
			since = now - last_switch;
			if (want != relay_lvl && (last_switch == 0 || since >= min_cycle)) begin
				relay_lvl = want;
				last_switch = now;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit control_relay(request_t rq);
			logic [31:0] held;
			logic want;
			held = rq.now_ms - ovr_start;
			if (ovr_length != 0 && held >= ovr_length)
				clear_override();
			cutoff = rq.reading_ok && (rq.temperature >= upper_limit);
			if (cutoff)
				return drive_relay(1'b0, rq.now_ms);
			if (ovr_mode == trc_pkg::OVR_ON)
				return drive_relay(1'b1, rq.now_ms);
			if (ovr_mode == trc_pkg::OVR_OFF)
				return drive_relay(1'b0, rq.now_ms);
			if (!rq.reading_ok || !rq.schedule_on)
				return drive_relay(1'b0, rq.now_ms);
			want = relay_lvl;
			if (rq.temperature < rq.on_below_temp)
				want = 1'b1;
			else if (rq.temperature > rq.off_above_temp)
				want = 1'b0;
			return drive_relay(want, rq.now_ms);
		endfunction

		function void note_request(request_t rq);
			status_t st;
			logic [31:0] elapsed;
			st.relay_changed = 1'b0;
			case (rq.command)
				trc_pkg::CMD_EVAL: st.relay_changed = control_relay(rq);
				trc_pkg::CMD_SET: begin
					if (rq.override_request != trc_pkg::OVR_BAD) begin
						ovr_mode = rq.override_request;
						ovr_length = rq.override_length_ms;
						ovr_start = (rq.override_length_ms != 0) ? rq.now_ms : '0;
					end
				end
				trc_pkg::CMD_CLEAR: clear_override();
				default: ;
			endcase
			st.override_remaining_ms = '0;
			if (ovr_mode != trc_pkg::OVR_NONE && ovr_length != 0) begin
				elapsed = rq.now_ms - ovr_start;
				if (elapsed < ovr_length)
					st.override_remaining_ms = ovr_length - elapsed;
			end
			st.relay_state = relay_lvl;
			st.cutoff_active = cutoff;
			st.override_now = ovr_mode;
			st.last_switch_ms = last_switch;
			due_results.push_back(st);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(status_t got);
			status_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual relay %0b last switch %0h",
					$time, got.relay_state, got.last_switch_ms);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("relay_state", want.relay_state, got.relay_state);
			compare_field("relay_changed", want.relay_changed, got.relay_changed);
			compare_field("cutoff_active", want.cutoff_active, got.cutoff_active);
			compare_field("override_now", want.override_now, got.override_now);
			compare_field("override_remaining_ms", want.override_remaining_ms,
				got.override_remaining_ms);
			compare_field("last_switch_ms", want.last_switch_ms, got.last_switch_ms);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	trc_pkg::reg_idx_t wr_index;
	logic [31:0]       wr_data;

	trc_in_if #(.TIME_BITS(32), .TEMP_BITS(16)) req_if ();
	trc_out_if #(.TIME_BITS(32)) res_if ();

	thermostat_relay_controller_unit #(.TIME_BITS(32), .TEMP_BITS(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_if),
		.result(res_if),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	thermostat_shadow shadow = new();
	int          send_idle_pct = 31;
	int          recv_idle_pct = 31;
	bit          hold_req = 1'b0;
	int          band_mid = 0;
	logic [31:0] clock_ms = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_request(input request_t rq);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.command <= rq.command;
		req_if.now_ms <= rq.now_ms;
		req_if.temperature <= rq.temperature;
		req_if.on_below_temp <= rq.on_below_temp;
		req_if.off_above_temp <= rq.off_above_temp;
		req_if.schedule_on <= rq.schedule_on;
		req_if.reading_ok <= rq.reading_ok;
		req_if.override_request <= rq.override_request;
		req_if.override_length_ms <= rq.override_length_ms;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		shadow.note_request(rq);
	endtask

	task automatic wait_idle();
		while (shadow.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input trc_pkg::reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		shadow.set_register(idx, value);
	endtask

	function automatic request_t request_of(trc_pkg::cmd_t command, logic [31:0] now,
		logic signed [15:0] temp, logic signed [15:0] open_t, logic signed [15:0] close_t,
		logic sched, logic valid, trc_pkg::ovr_t ovr, logic [31:0] length);
		request_t rq;
		rq.command = command;
		rq.now_ms = now;
		rq.temperature = temp;
		rq.on_below_temp = open_t;
		rq.off_above_temp = close_t;
		rq.schedule_on = sched;
		rq.reading_ok = valid;
		rq.override_request = ovr;
		rq.override_length_ms = length;
		return rq;
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			clock_ms = $urandom;
		else if (roll < 4)
			clock_ms = '0;
		else if (roll < 20)
			clock_ms += $urandom_range(400000, 100000);
		else
			clock_ms += $urandom_range(60000);
		rq.now_ms = clock_ms;
		roll = $urandom_range(99);
		if (roll < 80)
			rq.command = trc_pkg::CMD_EVAL;
		else if (roll < 89)
			rq.command = trc_pkg::CMD_SET;
		else if (roll < 96)
			rq.command = trc_pkg::CMD_CLEAR;
		else
			rq.command = CMD_UNKNOWN;
		if ($urandom_range(9) == 0) begin
			rq.temperature = 16'($urandom);
			rq.on_below_temp = 16'($urandom);
			rq.off_above_temp = 16'($urandom);
		end else begin
			rq.temperature = 16'(band_mid + int'($urandom_range(256)) - 128);
			rq.on_below_temp = 16'(band_mid - int'($urandom_range(64)));
			rq.off_above_temp = 16'(band_mid + int'($urandom_range(64)));
		end
		rq.schedule_on = ($urandom_range(9) != 0);
		rq.reading_ok = ($urandom_range(9) != 0);
		rq.override_request = trc_pkg::ovr_t'($urandom_range(3));
		roll = $urandom_range(3);
		if (roll == 0)
			rq.override_length_ms = '0;
		else if (roll == 3)
			rq.override_length_ms = $urandom;
		else
			rq.override_length_ms = $urandom_range(400000, 1);
		return rq;
	endfunction

	task automatic run_phase(input logic signed [15:0] upper, input logic [31:0] cycle,
		input int mid, input int count, input int idle_pct, input bit hold);
		wait_idle();
		write_reg(trc_pkg::REG_UPPER_LIMIT, {16'($urandom), upper});
		write_reg(trc_pkg::REG_MIN_CYCLE, cycle);
		band_mid = mid;
		send_idle_pct = idle_pct;
		recv_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			if (hold && n == count / 4)
				hold_req = 1'b1;
			if (n == count / 2) begin
				req_if.valid <= 1'b0;
				wait_idle();
			end
			send_request(random_request());
		end
		req_if.valid <= 1'b0;
	endtask

	initial begin
		status_t got;
		int hold_left;
		hold_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.relay_state = res_if.relay_state;
				got.relay_changed = res_if.relay_changed;
				got.cutoff_active = res_if.cutoff_active;
				got.override_now = res_if.override_now;
				got.override_remaining_ms = res_if.override_remaining_ms;
				got.last_switch_ms = res_if.last_switch_ms;
				shadow.check_result(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = trc_pkg::REG_UPPER_LIMIT;
		wr_data = '0;
		req_if.valid = 1'b0;
		req_if.command = trc_pkg::CMD_EVAL;
		req_if.now_ms = '0;
		req_if.temperature = '0;
		req_if.on_below_temp = '0;
		req_if.off_above_temp = '0;
		req_if.schedule_on = 1'b0;
		req_if.reading_ok = 1'b0;
		req_if.override_request = trc_pkg::OVR_NONE;
		req_if.override_length_ms = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset configuration.
		send_request(request_of(trc_pkg::CMD_EVAL, 0, 100, 200, 300, 1, 1, trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 10, 400, 200, 300, 1, 1, trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 20, 100, 200, 300, 1, 1, trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 300010, 100, 200, 300, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 300020, 250, 200, 300, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 600010, 560, 200, 300, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 600020, 32767, 200, 300, 1, 0,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_SET, 900000, 0, 0, 0, 0, 0, trc_pkg::OVR_ON, 1000));
		send_request(request_of(trc_pkg::CMD_EVAL, 900500, 250, 200, 300, 0, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 901000, 250, 200, 300, 0, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_SET, 901100, 0, 0, 0, 1, 1, trc_pkg::OVR_OFF, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 1300000, 100, 200, 300, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_SET, 1300010, 0, 0, 0, 1, 1,
			trc_pkg::OVR_NONE, 5000));
		send_request(request_of(trc_pkg::CMD_EVAL, 1300020, 100, 200, 300, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_SET, 1300030, 0, 0, 0, 1, 1,
			trc_pkg::OVR_BAD, 7777));
		send_request(request_of(trc_pkg::CMD_SET, 1300040, 0, 0, 0, 1, 1,
			trc_pkg::OVR_ON, 32'hffff_ffff));
		send_request(request_of(trc_pkg::CMD_CLEAR, 1300050, 0, 0, 0, 1, 1,
			trc_pkg::OVR_OFF, 1));
		send_request(request_of(CMD_UNKNOWN, 1300060, 0, 0, 0, 1, 1, trc_pkg::OVR_ON, 5));
		send_request(request_of(trc_pkg::CMD_EVAL, 1700000, -32768, -32768, 32767, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 32'hffff_fff0, -32768, 32767, -32768, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 32'h0000_1000, 32767, 32767, -32768, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_SET, 32'hffff_ff00, 0, 0, 0, 1, 1,
			trc_pkg::OVR_OFF, 32'h200));
		send_request(request_of(trc_pkg::CMD_EVAL, 32'h0000_0050, 100, 200, 300, 1, 1,
			trc_pkg::OVR_NONE, 0));
		send_request(request_of(trc_pkg::CMD_EVAL, 0, 400, 200, 300, 1, 1, trc_pkg::OVR_NONE, 0));
		req_if.valid <= 1'b0;

		run_phase(600, 300000, 400, 500, 31, 1'b1);
		run_phase(32767, 0, 0, 400, 31, 1'b0);
		run_phase(-32768, 32'hffff_ffff, -500, 200, 31, 1'b0);
		run_phase(100, 5000, 0, 400, 0, 1'b0);
		run_phase(800, 300000, 700, 300, 31, 1'b0);

		wait_idle();
		repeat (8) @(posedge clk);
		if (shadow.errors == 0 && shadow.due_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

/* sim.f */
+incdir+src
src/trc_pkg.sv
src/trc_in_if.sv
src/trc_out_if.sv
src/thermostat_relay_controller_unit.sv
tb/tb_top.sv
